FILE: src/reno_congestion_window_controller_defines.svh
// Assertion macros shared by the checker of the Reno window controller.
// Depends on nothing; included by the checker file only.
`ifndef RENO_CONGESTION_WINDOW_CONTROLLER_DEFINES_SVH
`define RENO_CONGESTION_WINDOW_CONTROLLER_DEFINES_SVH
// Implication checked on every clock edge outside reset
`define RCW_ASSERT_IMP(label, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
    else $error("rcw check failed");
// Next-cycle implication checked outside reset
`define RCW_ASSERT_NXT(label, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
    else $error("rcw check failed");
`endif

FILE: src/rcw_pkg.sv
// Package for the Reno window controller: codes, phases, reset constants.
// Used by the table scanner, the top level and the checker.
package rcw_pkg;

  localparam int MaxWindow  = 64;
  localparam int SeqModulus = 99998;
  localparam int SeqW       = 17;
  localparam int WinW       = 7;
  localparam int RttW       = 35;

  localparam logic [RttW-1:0] InitEst = 35'(500000 * 8);
  localparam logic [RttW-1:0] InitDev = 35'(250000 * 8);
  localparam logic [31:0]     InitRto = 32'd1000000;

  typedef enum logic [1:0] {
    KIND_SEND = 2'd0,
    KIND_ACK  = 2'd1,
    KIND_TICK = 2'd2,
    KIND_NONE = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    PH_SS = 2'd0,
    PH_CA = 2'd1,
    PH_FR = 2'd2
  } phase_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_ACK_HIT,
    ST_RTT0,
    ST_RTT1,
    ST_RTT2,
    ST_DUP,
    ST_DUP_SCAN,
    ST_DUP_HIT,
    ST_WIN,
    ST_OUT
  } state_t;

  // Scan request: mode of match, key and bound
  typedef enum logic [1:0] {
    SCAN_FREE,
    SCAN_SEQ,
    SCAN_OLD
  } scan_mode_t;

  typedef struct packed {
    logic       start;
    scan_mode_t mode;
    logic [SeqW-1:0] key;
    logic [31:0]     now;
    logic [31:0]     rto;
    logic [10:0]     bound;
  } scan_req_t;

  // Cap a window value to the effective limit
  function automatic logic [10:0] cap_window(input logic [11:0] w, input logic [10:0] lim);
    cap_window = (w > {1'b0, lim}) ? lim : w[10:0];
  endfunction

endpackage

FILE: src/reno_congestion_window_controller.sv
// Reno congestion window controller: one item in, one result word out.
// The time an item takes from one accepted input word to the next depends on its
// kind and is bounded by the table scanner, which reads one slot per cycle (a
// send scans up to cwnd slots, an ack up to two full passes plus the RTT update,
// a tick one pass, an unknown kind none). Ready (stall low) is
// shown only between items; the result word waits in an output register, so
// the next item may start while it is still held by the receiver.
// Depends on rcw_pkg and rcw_table.
module reno_congestion_window_controller #(
  parameter int MAX_WINDOW = rcw_pkg::MaxWindow,
  localparam int IdxW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [6:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  kind,
  input  logic [16:0] send_seq,
  input  logic [16:0] ack_value,
  input  logic [31:0] now_us,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        accepted,
  output logic        retransmit,
  output logic [16:0] retransmit_seq,
  output logic [6:0]  window_size,
  output logic [1:0]  cc_phase,
  output logic [31:0] timeout_us
);

  localparam int RttW = rcw_pkg::RttW;

  rcw_pkg::state_t state, state_next;
  logic [6:0]  limit;
  logic [10:0] lim_eff;
  logic [10:0] cwnd, ssthresh, outstanding;
  rcw_pkg::phase_t phase;
  logic [16:0] dup_seq;
  logic        dup_known;
  logic [2:0]  dup_cnt;
  logic [RttW-1:0] est, dev;
  logic [31:0] rto;

  logic [1:0]  k;
  logic [16:0] sseq, ackv;
  logic [31:0] now;

  rcw_pkg::scan_req_t req;
  logic sc_done, sc_hit, sc_res;
  logic [IdxW-1:0] sc_idx;
  logic [16:0] sc_seq;
  logic [31:0] sc_time;
  logic wr_en, wr_valid, wr_seq_en, wr_res;
  logic [IdxW-1:0] wr_idx;
  logic [31:0] wr_time;

  logic [RttW-1:0] s8, acc;
  logic resend_r;
  logic [16:0] rseq_r;
  logic acc_r;
  logic [12:0] dm;
  logic out_load;

  // Effective limit: 0 reads as 1, saturate at table size
  always_comb begin
    if (limit == 7'd0) lim_eff = 11'd1;
    else if (32'(limit) > 32'(MAX_WINDOW)) lim_eff = 11'(MAX_WINDOW);
    else lim_eff = {4'd0, limit};
  end

  // Divide by three of an 11-bit value via reciprocal
  function automatic logic [10:0] div3(input logic [10:0] v);
    logic [21:0] p;
    p = 22'(v) * 22'd683;
    div3 = p[21:11];
  endfunction

  rcw_table #(.MAX_WINDOW(MAX_WINDOW)) u_table (
    .clk, .rst, .req, .done(sc_done), .hit(sc_hit), .hit_idx(sc_idx),
    .hit_seq(sc_seq), .hit_time(sc_time), .hit_resent(sc_res),
    .wr_en, .wr_idx, .wr_valid, .wr_seq_en, .wr_seq(sseq), .wr_time, .wr_resent(wr_res)
  );

  assign in_stall = (state != rcw_pkg::ST_IDLE);
  assign s8 = {(RttW-32)'(0), now - sc_time} << 3;
  // Load the result word once the output register is free
  assign out_load = (state == rcw_pkg::ST_OUT) && !(out_valid && out_stall);

  // Hold state register
  always_ff @(posedge clk) begin
    if (rst) state <= rcw_pkg::ST_IDLE;
    else state <= state_next;
  end

  // Next state, scanner requests and table writes
  always_comb begin
    state_next = state;
    req = '0;
    req.now = now;
    req.rto = rto;
    wr_en = 1'b0; wr_idx = sc_idx; wr_valid = 1'b1; wr_seq_en = 1'b0;
    wr_time = now; wr_res = 1'b1;
    case (state)
      rcw_pkg::ST_IDLE: begin
        if (in_valid && !in_stall) begin
          case (rcw_pkg::kind_t'(kind))
            rcw_pkg::KIND_SEND: begin
              req.start = 1'b1; req.mode = rcw_pkg::SCAN_FREE;
              req.bound = (outstanding < cwnd)
                ? ((cwnd > 11'(MAX_WINDOW)) ? 11'(MAX_WINDOW) : cwnd) : 11'd0;
              req.now = now_us;
              state_next = rcw_pkg::ST_SCAN;
            end
            rcw_pkg::KIND_ACK: begin
              req.start = 1'b1; req.mode = rcw_pkg::SCAN_SEQ;
              req.key = ack_value - 17'd1;
              req.bound = (ack_value != 17'd0) ? 11'(MAX_WINDOW) : 11'd0;
              state_next = rcw_pkg::ST_SCAN;
            end
            rcw_pkg::KIND_TICK: begin
              req.start = 1'b1; req.mode = rcw_pkg::SCAN_OLD;
              req.bound = 11'(MAX_WINDOW); req.now = now_us;
              state_next = rcw_pkg::ST_SCAN;
            end
            default: state_next = rcw_pkg::ST_OUT;
          endcase
        end
      end
      rcw_pkg::ST_SCAN: begin
        if (sc_done) begin
          if (k == rcw_pkg::KIND_SEND) begin
            if (sc_hit) begin
              wr_en = 1'b1; wr_seq_en = 1'b1; wr_res = 1'b0;
            end
            state_next = rcw_pkg::ST_OUT;
          end else if (k == rcw_pkg::KIND_ACK) begin
            state_next = sc_hit ? rcw_pkg::ST_ACK_HIT : rcw_pkg::ST_DUP;
          end else begin
            if (sc_hit) begin
              wr_en = 1'b1; wr_res = 1'b1;
            end
            state_next = rcw_pkg::ST_OUT;
          end
        end
      end
      rcw_pkg::ST_ACK_HIT: begin
        wr_en = 1'b1; wr_valid = 1'b0; wr_time = sc_time; wr_res = sc_res;
        state_next = sc_res ? rcw_pkg::ST_DUP : rcw_pkg::ST_RTT0;
      end
      rcw_pkg::ST_RTT0: state_next = rcw_pkg::ST_RTT1;
      rcw_pkg::ST_RTT1: state_next = rcw_pkg::ST_RTT2;
      rcw_pkg::ST_RTT2: state_next = rcw_pkg::ST_DUP;
      rcw_pkg::ST_DUP: begin
        if (dup_cnt == 3'd3) begin
          req.start = 1'b1; req.mode = rcw_pkg::SCAN_SEQ; req.key = dup_seq;
          req.bound = 11'(MAX_WINDOW);
          state_next = rcw_pkg::ST_DUP_SCAN;
        end else begin
          state_next = rcw_pkg::ST_WIN;
        end
      end
      rcw_pkg::ST_DUP_SCAN: begin
        if (sc_done) begin
          if (sc_hit) wr_en = 1'b1;
          state_next = rcw_pkg::ST_OUT;
        end
      end
      rcw_pkg::ST_WIN: state_next = rcw_pkg::ST_OUT;
      rcw_pkg::ST_OUT: state_next = out_load ? rcw_pkg::ST_IDLE : rcw_pkg::ST_OUT;
      default: state_next = rcw_pkg::ST_IDLE;
    endcase
  end

  assign dm = 13'(cwnd) * 13'd2;

  // Datapath: congestion state, RTT estimator and result word
  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= 7'd64;
      cwnd <= 11'd1; outstanding <= '0; phase <= rcw_pkg::PH_SS;
      ssthresh <= 11'(((MAX_WINDOW < 64) ? MAX_WINDOW : 64) / 3);
      dup_seq <= '0; dup_known <= 1'b0; dup_cnt <= '0;
      est <= rcw_pkg::InitEst; dev <= rcw_pkg::InitDev; rto <= rcw_pkg::InitRto;
      out_valid <= 1'b0;
    end else begin
      // Raise the result word when loaded, drop it once taken
      if (out_load) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
      if (cfg_we) begin
        limit <= cfg_wdata;
        ssthresh <= div3((cfg_wdata == 7'd0) ? 11'd1
          : ((32'(cfg_wdata) > 32'(MAX_WINDOW)) ? 11'(MAX_WINDOW) : {4'd0, cfg_wdata}));
      end
      case (state)
        rcw_pkg::ST_IDLE: begin
          if (in_valid && !in_stall) begin
            k <= kind; sseq <= send_seq; ackv <= ack_value; now <= now_us;
            acc_r <= 1'b0; resend_r <= 1'b0; rseq_r <= '0;
          end
        end
        rcw_pkg::ST_SCAN: begin
          if (sc_done && sc_hit) begin
            if (k == rcw_pkg::KIND_SEND) begin
              acc_r <= 1'b1; outstanding <= outstanding + 11'd1;
            end else if (k == rcw_pkg::KIND_TICK) begin
              resend_r <= 1'b1; rseq_r <= sc_seq; phase <= rcw_pkg::PH_SS;
              ssthresh <= cwnd >> 1; cwnd <= rcw_pkg::cap_window(12'd1, lim_eff);
              dup_cnt <= '0; dup_known <= 1'b0; dup_seq <= '0;
            end
          end
          if (sc_done && k == rcw_pkg::KIND_ACK) begin
            if (dup_known && dup_seq == ackv) begin
              if (dup_cnt < 3'd4) dup_cnt <= dup_cnt + 3'd1;
            end else begin
              dup_cnt <= '0; dup_seq <= ackv; dup_known <= 1'b1;
            end
          end
        end
        rcw_pkg::ST_ACK_HIT: begin
          if (outstanding != 11'd0) outstanding <= outstanding - 11'd1;
          acc <= (s8 >= est) ? (s8 - est) : (est - s8);
        end
        // Deviation from old estimate, then estimate, then timeout
        rcw_pkg::ST_RTT0: begin
          dev <= RttW'(((RttW+2)'(dev) * 3 + (RttW+2)'(acc)) >> 2);
        end
        rcw_pkg::ST_RTT1: begin
          est <= RttW'(((RttW+3)'(est) * 7 + (RttW+3)'(s8)) >> 3);
        end
        rcw_pkg::ST_RTT2: begin
          acc <= RttW'(0);
          if ((((RttW+3)'(est) + ((RttW+3)'(dev) << 2)) >> 3) > (RttW+3)'(32'hFFFF_FFFF))
            rto <= 32'hFFFF_FFFF;
          else
            rto <= 32'(((RttW+3)'(est) + ((RttW+3)'(dev) << 2)) >> 3);
        end
        rcw_pkg::ST_DUP_SCAN: begin
          if (sc_done && sc_hit) begin
            resend_r <= 1'b1; rseq_r <= sc_seq; phase <= rcw_pkg::PH_FR;
            ssthresh <= cwnd >> 1;
            cwnd <= rcw_pkg::cap_window(12'(cwnd >> 1) + 12'd3, lim_eff);
          end
        end
        rcw_pkg::ST_WIN: begin
          if (dup_cnt > 3'd3) begin
            cwnd <= rcw_pkg::cap_window(12'(cwnd) + 12'd1, lim_eff);
          end else if (phase == rcw_pkg::PH_SS) begin
            cwnd <= rcw_pkg::cap_window(dm[11:0], lim_eff);
            if (rcw_pkg::cap_window(dm[11:0], lim_eff) > ssthresh) phase <= rcw_pkg::PH_CA;
          end else if (phase == rcw_pkg::PH_FR) begin
            phase <= rcw_pkg::PH_CA;
            cwnd <= rcw_pkg::cap_window(12'(ssthresh), lim_eff);
          end else begin
            cwnd <= rcw_pkg::cap_window(12'(cwnd) + 12'd1, lim_eff);
          end
        end
        rcw_pkg::ST_OUT: begin
          if (out_load) begin
            accepted <= acc_r; retransmit <= resend_r; retransmit_seq <= rseq_r;
            window_size <= cwnd[6:0]; cc_phase <= phase; timeout_us <= rto;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

FILE: src/rcw_table.sv
// Table of unacknowledged packets with a one-slot-per-cycle scanner.
// Depends on rcw_pkg. Valid bits in flip-flops, payload in memories.
module rcw_table #(
  parameter int MAX_WINDOW = rcw_pkg::MaxWindow,
  localparam int IdxW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  rcw_pkg::scan_req_t    req,
  output logic                  done,
  output logic                  hit,
  output logic [IdxW-1:0]       hit_idx,
  output logic [rcw_pkg::SeqW-1:0] hit_seq,
  output logic [31:0]           hit_time,
  output logic                  hit_resent,
  // write port
  input  logic                  wr_en,
  input  logic [IdxW-1:0]       wr_idx,
  input  logic                  wr_valid,
  input  logic                  wr_seq_en,
  input  logic [rcw_pkg::SeqW-1:0] wr_seq,
  input  logic [31:0]           wr_time,
  input  logic                  wr_resent
);

  logic [MAX_WINDOW-1:0]  valid;
  logic [rcw_pkg::SeqW-1:0] seq_mem [MAX_WINDOW];
  logic [31:0]            time_mem [MAX_WINDOW];
  logic                   res_mem  [MAX_WINDOW];

  logic                   busy;
  logic [10:0]            pos;
  logic                   rd_live;
  logic [IdxW-1:0]        rd_idx;
  rcw_pkg::scan_req_t     cur;
  logic [31:0]            age;
  logic                   match;
  logic                   last;
  logic                   step;

  // Write slot payload and valid
  always_ff @(posedge clk) begin
    if (wr_en) begin
      if (wr_seq_en) seq_mem[wr_idx] <= wr_seq;
      time_mem[wr_idx] <= wr_time;
      res_mem[wr_idx]  <= wr_resent;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr_en) begin
      valid[wr_idx] <= wr_valid;
    end
  end

  // Advance only while the slot under test does not end the scan
  assign last = ({1'b0, rd_idx} + 11'd1) >= cur.bound;
  assign step = busy && !req.start && !(rd_live && (match || last));

  // Registered read of the slot under the scan pointer; hold it once the scan ends
  always_ff @(posedge clk) begin
    if (step) begin
      hit_seq    <= seq_mem[pos[IdxW-1:0]];
      hit_time   <= time_mem[pos[IdxW-1:0]];
      hit_resent <= res_mem[pos[IdxW-1:0]];
    end
  end

  assign age = cur.now - hit_time;

  always_comb begin
    case (cur.mode)
      rcw_pkg::SCAN_FREE: match = !valid[rd_idx];
      rcw_pkg::SCAN_SEQ:  match = valid[rd_idx] && (hit_seq == cur.key);
      rcw_pkg::SCAN_OLD:  match = valid[rd_idx] && (age > cur.rto);
      default:            match = 1'b0;
    endcase
  end

  // Advance pointer one slot a cycle; stop on match or bound
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      hit <= 1'b0;
      rd_live <= 1'b0;
      pos <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        cur <= req;
        pos <= '0;
        rd_live <= 1'b0;
        hit <= 1'b0;
        if (req.bound == 11'd0) begin
          done <= 1'b1;
        end else begin
          busy <= 1'b1;
        end
      end else if (busy) begin
        if (rd_live && match) begin
          busy <= 1'b0; done <= 1'b1; hit <= 1'b1; hit_idx <= rd_idx;
          rd_live <= 1'b0;
        end else if (rd_live && last) begin
          busy <= 1'b0; done <= 1'b1; rd_live <= 1'b0;
        end else begin
          rd_idx <= pos[IdxW-1:0];
          rd_live <= 1'b1;
          pos <= pos + 11'd1;
        end
      end
    end
  end

endmodule

FILE: src/rcw_checker.sv
// Port-level checker for the Reno window controller, bound to the top level.
// Depends on the defines header and rcw_pkg.
`include "reno_congestion_window_controller_defines.svh"
module rcw_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic        accepted,
  input logic        retransmit,
  input logic [16:0] retransmit_seq,
  input logic [1:0]  cc_phase
);
  // stalled result word stays valid, with sequence and phase unchanged
  `RCW_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(retransmit_seq) && $stable(cc_phase))
  // accepted word leaves input stalled next cycle
  `RCW_ASSERT_NXT(a_take_stall, in_valid && !in_stall, in_stall)
  // no resend, no sequence
  `RCW_ASSERT_IMP(a_rseq_zero, out_valid && !retransmit, retransmit_seq == 17'd0)
  // send never resends
  `RCW_ASSERT_IMP(a_send_no_resend, out_valid && accepted, !retransmit)
  // phase code always known
  `RCW_ASSERT_IMP(a_phase_ok, out_valid, cc_phase <= rcw_pkg::PH_FR)
endmodule

bind reno_congestion_window_controller rcw_checker u_rcw_checker (
  .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall, .accepted,
  .retransmit, .retransmit_seq, .cc_phase
);
